// ===== src/ssnf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssnf_pkg: shared types and constants of the seven-segment number formatter
// Request and write beat structs, the formatted-entry struct passed from the
// front pipeline to the write sequencer, request codes and the glyph table.
// ----------------------------------------------------------------------------
package ssnf_pkg;

	// Request codes
	typedef enum logic [2:0] {
		REQ_DEC       = 3'd0,
		REQ_HEX       = 3'd1,
		REQ_DEC_LAST  = 3'd2,
		REQ_DEC_POINT = 3'd3,
		REQ_TIME      = 3'd4,
		REQ_CLEAR     = 3'd5,
		REQ_POINT     = 3'd6,
		REQ_UNUSED    = 3'd7
	} req_kind_t;

	localparam logic [6:0] ADDR_DIGIT1 = 7'h68;
	localparam logic [7:0] SEG_POINT   = 8'h80;
	localparam logic [7:0] SEG_BLANK   = 8'h00;
	localparam int         NumDigits   = 4;
	localparam int         QueueDepth  = 4;
	localparam int         QPtrW       = $clog2(QueueDepth);

	// Reciprocal constants for division by constants (multiply, then shift)
	localparam logic [16:0] RECIP_1000  = 17'd67109; // 2^26 / 1000
	localparam int          SHIFT_1000  = 26;
	localparam logic [16:0] RECIP_100   = 17'd83887; // 2^23 / 100, 16-bit inputs
	localparam int          SHIFT_100   = 23;
	localparam logic [15:0] RECIP_10    = 16'd52429; // 2^19 / 10, 16-bit inputs
	localparam int          SHIFT_10    = 19;
	localparam logic [7:0]  RECIP_10_S  = 8'd205;    // 2^11 / 10, inputs below 1029
	localparam int          SHIFT_10_S  = 11;

	// One display request
	typedef struct packed {
		logic [2:0]  req_type;
		logic [15:0] value;
		logic        blank_leading;
		logic [2:0]  shown_digits;
		logic [2:0]  point_position;
		logic        point_on;
		logic [3:0]  minutes;
		logic [5:0]  seconds;
		logic [3:0]  tenths;
		logic        minute_point;
		logic [2:0]  blink_position;
	} req_t;

	// One digit register write
	typedef struct packed {
		logic [6:0] digit_address;
		logic [7:0] segment_byte;
		logic       last_write;
	} res_t;

	// Formatted request: four segment bytes, or one lone write to a chosen digit
	typedef struct packed {
		logic [NumDigits-1:0][7:0] seg;
		logic                      single;
		logic [1:0]                digit;
	} fmt_t;

	function automatic logic [7:0] glyph(input logic [3:0] d);
		logic [7:0] g;
		case (d)
			4'h0: g = 8'h3F;
			4'h1: g = 8'h06;
			4'h2: g = 8'h5B;
			4'h3: g = 8'h4F;
			4'h4: g = 8'h66;
			4'h5: g = 8'h6D;
			4'h6: g = 8'h7D;
			4'h7: g = 8'h07;
			4'h8: g = 8'h7F;
			4'h9: g = 8'h6F;
			4'hA: g = 8'h77;
			4'hB: g = 8'h7C;
			4'hC: g = 8'h39;
			4'hD: g = 8'h5E;
			4'hE: g = 8'h79;
			4'hF: g = 8'h71;
			default: g = SEG_BLANK;
		endcase
		return g;
	endfunction

endpackage
`default_nettype wire

// ===== src/seven_segment_number_formatter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_number_formatter: four-digit seven-segment write generator
// Turns display requests into digit register writes (address, segment byte,
// last flag) for decimal, hex, last-N, decimal point, time, clear and lone
// point modes.
// ----------------------------------------------------------------------------
// A request is taken whenever full is low and pushes through a three-stage
// formatting pipeline into a four-entry queue. Writes leave one per cycle,
// while pop keeps up, through a registered output beat: a full request gives
// four writes, a lone-point request one, all through the single write port.
// The queue between the pipeline and the write sequencer lets the input keep
// accepting while results wait to be popped. Unused request codes and
// lone-point requests naming no digit produce no writes.
module seven_segment_number_formatter (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	output logic           full,
	input  ssnf_pkg::req_t req,
	output logic           empty,
	input  wire            pop,
	output ssnf_pkg::res_t res
);
	import ssnf_pkg::*;

	logic enq;
	logic enq_full;
	fmt_t enq_data;
	logic q_empty;
	logic q_rd;
	fmt_t q_head;

	// Front: accept and format
	ssnf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req      (req),
		.enq_full (enq_full),
		.enq      (enq),
		.enq_data (enq_data)
	);

	// Decoupling queue
	ssnf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (enq),
		.wr_data (enq_data),
		.q_full  (enq_full),
		.rd      (q_rd),
		.q_empty (q_empty),
		.head    (q_head)
	);

	// Back: sequence digit writes
	ssnf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (q_head),
		.rd      (q_rd),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

endmodule
`default_nettype wire

// ===== src/ssnf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssnf_front: request pipeline
// Accepts requests, splits the value into decimal digits by reciprocal
// multiplication over three stages, applies the mode rules and pushes one
// formatted entry per request that produces writes.
// ----------------------------------------------------------------------------
module ssnf_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  ssnf_pkg::req_t      req,
	input  wire                 enq_full,
	output logic                enq,
	output ssnf_pkg::fmt_t      enq_data
);
	import ssnf_pkg::*;

	logic        v_s1, v_s2, v_s3;
	req_t        req_s1, req_s2, req_s3;
	logic [6:0]  q1_s2, q1_s3;   // value / 1000
	logic [9:0]  q2_s2, q2_s3;   // value / 100
	logic [12:0] q3_s2, q3_s3;   // value / 10
	logic [2:0]  st_s2;          // seconds / 10
	logic [3:0]  st_s3;
	logic [3:0]  so_s3;          // seconds % 10
	logic [3:0]  t1_s3;          // q1 / 10
	logic [6:0]  t2_s3;          // q2 / 10
	logic [9:0]  t3_s3;          // q3 / 10

	logic        has_res;
	logic        adv;
	fmt_t        fmt;

	// Whole pipeline moves unless the last stage holds an entry the queue cannot take
	assign adv  = !(v_s3 && has_res && enq_full);
	assign full = !adv;
	assign enq  = v_s3 && has_res && !enq_full;
	assign enq_data = fmt;

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1 captures the request; stage 2 takes the quotients; stage 3 divides them by ten and splits the seconds
	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= req;
			req_s2 <= req_s1;
			req_s3 <= req_s2;
			q1_s2  <= 7'((34'(req_s1.value) * 34'(RECIP_1000)) >> SHIFT_1000);
			q2_s2  <= 10'((34'(req_s1.value) * 34'(RECIP_100)) >> SHIFT_100);
			q3_s2  <= 13'((32'(req_s1.value) * 32'(RECIP_10)) >> SHIFT_10);
			st_s2  <= 3'((14'(req_s1.seconds) * 14'(RECIP_10_S)) >> SHIFT_10_S);
			q1_s3  <= q1_s2;
			q2_s3  <= q2_s2;
			q3_s3  <= q3_s2;
			st_s3  <= {1'b0, st_s2};
			so_s3  <= 4'(req_s2.seconds - 6'(st_s2) * 6'd10);
			t1_s3  <= 4'((15'(q1_s2) * 15'(RECIP_10_S)) >> SHIFT_10_S);
			t2_s3  <= 7'((18'(q2_s2) * 18'(RECIP_10_S)) >> SHIFT_10_S);
			t3_s3  <= 10'((29'(q3_s2) * 29'(RECIP_10)) >> SHIFT_10);
		end
	end

	// Stage 3: digit remainders, glyphs and mode rules
	always_comb begin
		logic [3:0][3:0] dig;
		logic [15:0]     val;
		logic [2:0]      ndig;
		logic [1:0]      pidx;
		logic [1:0]      bidx;
		logic            pvalid;
		logic            bvalid;
		val    = req_s3.value;
		pvalid = (req_s3.point_position >= 3'd1) && (req_s3.point_position <= 3'd4);
		bvalid = (req_s3.blink_position >= 3'd1) && (req_s3.blink_position <= 3'd4);
		pidx   = 2'(req_s3.point_position - 3'd1);
		bidx   = 2'(req_s3.blink_position - 3'd1);
		ndig   = (req_s3.shown_digits > 3'd4) ? 3'd4 : req_s3.shown_digits;

		if (req_s3.req_type == REQ_HEX) begin
			dig[0] = val[15:12];
			dig[1] = val[11:8];
			dig[2] = val[7:4];
			dig[3] = val[3:0];
		end else begin
			dig[0] = 4'(q1_s3 - 7'(t1_s3) * 7'd10);
			dig[1] = 4'(q2_s3 - 10'(t2_s3) * 10'd10);
			dig[2] = 4'(q3_s3 - 13'(t3_s3) * 13'd10);
			dig[3] = 4'(val - 16'(q3_s3) * 16'd10);
		end

		for (int i = 0; i < NumDigits; i++) begin
			fmt.seg[i] = glyph(dig[i]);
		end
		fmt.single = 1'b0;
		fmt.digit  = 2'd0;
		has_res    = 1'b1;

		case (req_s3.req_type)
			REQ_DEC: begin
				if (req_s3.blank_leading) begin
					if (val < 16'd1000) fmt.seg[0] = SEG_BLANK;
					if (val < 16'd100)  fmt.seg[1] = SEG_BLANK;
					if (val < 16'd10)   fmt.seg[2] = SEG_BLANK;
				end
			end
			REQ_HEX: begin
				if (req_s3.blank_leading) begin
					if (val < 16'h1000) fmt.seg[0] = SEG_BLANK;
					if (val < 16'h0100) fmt.seg[1] = SEG_BLANK;
					if (val < 16'h0010) fmt.seg[2] = SEG_BLANK;
				end
			end
			REQ_DEC_LAST: begin
				for (int i = 0; i < NumDigits; i++) begin
					if (3'(i) + ndig < 3'd4) fmt.seg[i] = SEG_BLANK;
				end
			end
			REQ_DEC_POINT: begin
				if (pvalid) fmt.seg[pidx] = fmt.seg[pidx] | SEG_POINT;
			end
			REQ_TIME: begin
				fmt.seg[0] = glyph(req_s3.minutes);
				fmt.seg[1] = glyph(st_s3);
				fmt.seg[2] = glyph(so_s3);
				fmt.seg[3] = glyph(req_s3.tenths);
				if (req_s3.minute_point) fmt.seg[0] = fmt.seg[0] | SEG_POINT;
				// point blinks on during the first half of each second
				if ((req_s3.tenths < 4'd5) && bvalid) begin
					fmt.seg[bidx] = fmt.seg[bidx] | SEG_POINT;
				end
			end
			REQ_CLEAR: begin
				for (int i = 0; i < NumDigits; i++) begin
					fmt.seg[i] = SEG_BLANK;
				end
			end
			REQ_POINT: begin
				fmt.single = 1'b1;
				fmt.digit  = pidx;
				fmt.seg[0] = req_s3.point_on ? SEG_POINT : SEG_BLANK;
				has_res    = pvalid;
			end
			default: begin
				has_res = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== src/ssnf_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssnf_queue: formatted-entry queue
// Small first-word-fall-through queue between the request pipeline and the
// write sequencer; the head entry is visible while q_empty is low.
// ----------------------------------------------------------------------------
module ssnf_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            wr,
	input  ssnf_pkg::fmt_t wr_data,
	output logic           q_full,
	input  wire            rd,
	output logic           q_empty,
	output ssnf_pkg::fmt_t head
);
	import ssnf_pkg::*;

	fmt_t           entry_q [QueueDepth];
	logic [QPtrW-1:0] wptr_q, rptr_q;
	logic [QPtrW:0]   count_q;

	assign q_full  = (count_q == (QPtrW+1)'(QueueDepth));
	assign q_empty = (count_q == '0);
	assign head    = entry_q[rptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) wptr_q <= wptr_q + 1'b1;
			if (rd) rptr_q <= rptr_q + 1'b1;
			case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (wr) entry_q[wptr_q] <= wr_data;
	end

endmodule
`default_nettype wire

// ===== src/ssnf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssnf_back: write sequencer
// Walks the head entry one digit per cycle, unless a beat waits for pop,
// into a registered output beat, flags the final write and retires the entry.
// ----------------------------------------------------------------------------
module ssnf_back (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            q_empty,
	input  ssnf_pkg::fmt_t head,
	output logic           rd,
	output logic           empty,
	input  wire            pop,
	output ssnf_pkg::res_t res
);
	import ssnf_pkg::*;

	logic [1:0] cnt_q;
	logic       out_v_q;
	res_t       res_q;
	logic       load;
	logic       last;
	logic [1:0] digit;

	assign load  = !q_empty && (!out_v_q || pop);
	assign last  = head.single || (cnt_q == 2'd3);
	assign digit = head.single ? head.digit : cnt_q;
	assign rd    = load && last;
	assign empty = !out_v_q;
	assign res   = res_q;

	// Beat counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 2'd0;
			out_v_q <= 1'b0;
		end else begin
			if (load) cnt_q <= last ? 2'd0 : cnt_q + 2'd1;
			if (load) out_v_q <= 1'b1;
			else if (pop) out_v_q <= 1'b0;
		end
	end

	// Output beat register
	always_ff @(posedge clk) begin
		if (load) begin
			res_q.digit_address <= ADDR_DIGIT1 + {4'b0, digit, 1'b0};
			res_q.segment_byte  <= head.single ? head.seg[0] : head.seg[cnt_q];
			res_q.last_write    <= last;
		end
	end

endmodule
`default_nettype wire

// ===== test/seven_segment_number_formatter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_number_formatter_test: self-checking bench for the formatter
// Feeds directed and random display requests through the push/full side,
// predicts the digit register writes of each accepted request and compares
// every popped write beat against them, with random stalls on both sides.
// ----------------------------------------------------------------------------
module seven_segment_number_formatter_test;
	import ssnf_pkg::*;

	localparam int QuietLimit  = 4000; // cycles without any accepted beat
	localparam int RandomReqs  = 194;
	localparam int CalmTail    = 40;   // last requests run without idling
	localparam int HoldAt      = 110;  // accepted count that starts the long hold
	localparam int HoldCycles  = 80;

	// Segment font, index 0 in the low byte
	localparam logic [15:0][7:0] DIGIT_FONT = {
		8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
		8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic push   = 1'b0;
	logic pop    = 1'b0;
	req_t req    = '0;
	logic full;
	logic empty;
	res_t res;

	req_t pending_reqs[$];
	res_t expected_writes[$];
	int   total_reqs     = 0;
	int   accepted_reqs  = 0;
	int   mismatch_count = 0;
	int   quiet_cycles   = 0;

	seven_segment_number_formatter i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.req   (req),
		.empty (empty),
		.pop   (pop),
		.res   (res)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Expected writes of one request, digits in order 1 to 4
	function automatic void predict_writes(input req_t r);
		logic [7:0]  seg [4];
		int unsigned dig [4];
		int unsigned v, n, pp, bp, sec;
		res_t        w;
		v   = r.value;
		pp  = r.point_position;
		bp  = r.blink_position;
		sec = r.seconds;
		if (r.req_type == REQ_HEX) begin
			dig[0] = r.value[15:12];
			dig[1] = r.value[11:8];
			dig[2] = r.value[7:4];
			dig[3] = r.value[3:0];
		end else begin
			dig[0] = (v / 1000) % 10;
			dig[1] = (v / 100) % 10;
			dig[2] = (v / 10) % 10;
			dig[3] = v % 10;
		end
		for (int i = 0; i < 4; i++)
			seg[i] = DIGIT_FONT[dig[i]];
		case (r.req_type)
			REQ_DEC: begin
				if (r.blank_leading) begin
					if (v < 1000) seg[0] = SEG_BLANK;
					if (v < 100) seg[1] = SEG_BLANK;
					if (v < 10) seg[2] = SEG_BLANK;
				end
			end
			REQ_HEX: begin
				if (r.blank_leading) begin
					if (v < 'h1000) seg[0] = SEG_BLANK;
					if (v < 'h100) seg[1] = SEG_BLANK;
					if (v < 'h10) seg[2] = SEG_BLANK;
				end
			end
			REQ_DEC_LAST: begin
				n = (r.shown_digits > 4) ? 4 : r.shown_digits;
				for (int i = 0; i < 4 - int'(n); i++)
					seg[i] = SEG_BLANK;
			end
			REQ_DEC_POINT: begin
				if (pp >= 1 && pp <= 4)
					seg[pp-1] = seg[pp-1] | SEG_POINT;
			end
			REQ_TIME: begin
				seg[0] = DIGIT_FONT[r.minutes];
				seg[1] = DIGIT_FONT[(sec / 10) % 16];
				seg[2] = DIGIT_FONT[sec % 10];
				seg[3] = DIGIT_FONT[r.tenths];
				if (r.minute_point) seg[0] = seg[0] | SEG_POINT;
				if (r.tenths < 5 && bp >= 1 && bp <= 4)
					seg[bp-1] = seg[bp-1] | SEG_POINT;
			end
			REQ_CLEAR: begin
				for (int i = 0; i < 4; i++)
					seg[i] = SEG_BLANK;
			end
			REQ_POINT: begin
				// lone point touches one digit only, none when the digit is invalid
				if (pp >= 1 && pp <= 4) begin
					w.digit_address = ADDR_DIGIT1 + 7'(2 * (pp - 1));
					w.segment_byte  = r.point_on ? SEG_POINT : SEG_BLANK;
					w.last_write    = 1'b1;
					expected_writes.push_back(w);
				end
				return;
			end
			default: return;
		endcase
		for (int i = 0; i < 4; i++) begin
			w.digit_address = ADDR_DIGIT1 + 7'(2 * i);
			w.segment_byte  = seg[i];
			w.last_write    = (i == 3);
			expected_writes.push_back(w);
		end
	endfunction

	// Random request content, biased toward digit boundaries and valid times
	function automatic req_t random_request(input logic [2:0] kind);
		req_t r;
		r.req_type = kind;
		case ($urandom_range(0, 5))
			0: r.value = 16'($urandom_range(0, 15));
			1: r.value = 16'($urandom_range(0, 999));
			2: r.value = 16'($urandom_range(0, 9999));
			3: r.value = 16'($urandom_range(9990, 10010));
			4: r.value = 16'($urandom_range(0, 'h1FFF));
			default: r.value = 16'($urandom);
		endcase
		r.blank_leading  = 1'($urandom);
		r.shown_digits   = 3'($urandom);
		r.point_position = 3'($urandom);
		r.point_on       = 1'($urandom);
		r.minutes  = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
		r.seconds  = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
		r.tenths   = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
		r.minute_point   = 1'($urandom);
		r.blink_position = 3'($urandom);
		return r;
	endfunction

	// No idling in the calm stretch and in the tail of the run
	function automatic bit idling_allowed();
		if (accepted_reqs >= total_reqs - CalmTail) return 1'b0;
		if (accepted_reqs >= 50 && accepted_reqs < 90) return 1'b0;
		return 1'b1;
	endfunction

	// Request driver: offers the next pending request, random gaps after beats
	always @(posedge clk) begin : request_driver
		int tx_gap;
		if (arst_n) begin
			if (push && !full) begin
				predict_writes(req);
				accepted_reqs <= accepted_reqs + 1;
			end
			if (!push || !full) begin
				if (tx_gap > 0) begin
					tx_gap--;
					push <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					push <= 1'b1;
					req  <= pending_reqs.pop_front();
					if (idling_allowed() && $urandom_range(0, 5) == 0)
						tx_gap = $urandom_range(1, 12);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Write monitor: checks each popped beat, random stalls and one long hold
	always @(posedge clk) begin : write_monitor
		int   rx_gap;
		int   hold_left;
		bit   hold_done;
		res_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_writes.size() == 0) begin
					$error("unexpected write beat: digit_address %0h segment_byte %0h last_write %0b",
						res.digit_address, res.segment_byte, res.last_write);
					mismatch_count++;
				end else begin
					want = expected_writes.pop_front();
					if (res.digit_address !== want.digit_address) begin
						$error("digit_address: expected %0h, actual %0h",
							want.digit_address, res.digit_address);
						mismatch_count++;
					end
					if (res.segment_byte !== want.segment_byte) begin
						$error("segment_byte: expected %0h, actual %0h",
							want.segment_byte, res.segment_byte);
						mismatch_count++;
					end
					if (res.last_write !== want.last_write) begin
						$error("last_write: expected %0b, actual %0b",
							want.last_write, res.last_write);
						mismatch_count++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (!hold_done && accepted_reqs >= HoldAt) begin
				// long hold so the block fills and raises full
				hold_done = 1'b1;
				hold_left = HoldCycles;
				pop <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if (idling_allowed() && $urandom_range(0, 5) == 0)
					rx_gap = $urandom_range(1, 12);
			end
		end
	end

	// Watchdog on beats in either direction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QuietLimit) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin : stimulus
		req_t r;
		// Directed: digit boundaries, blanking, modes and out-of-range cases
		r = random_request(REQ_DEC); r.value = 0; r.blank_leading = 1;
		pending_reqs.push_back(r);
		r = random_request(REQ_DEC); r.value = 9; r.blank_leading = 1;
		pending_reqs.push_back(r);
		r = random_request(REQ_DEC); r.value = 10; r.blank_leading = 1;
		pending_reqs.push_back(r);
		r = random_request(REQ_DEC); r.value = 999; r.blank_leading = 1;
		pending_reqs.push_back(r);
		r = random_request(REQ_DEC); r.value = 1000; r.blank_leading = 1;
		pending_reqs.push_back(r);
		r = random_request(REQ_DEC); r.value = 10005; r.blank_leading = 1;
		pending_reqs.push_back(r);
		r = random_request(REQ_DEC); r.value = 16'hFFFF; r.blank_leading = 1;
		pending_reqs.push_back(r);
		r = random_request(REQ_HEX); r.value = 16'h000F; r.blank_leading = 1;
		pending_reqs.push_back(r);
		r = random_request(REQ_HEX); r.value = 16'h0010; r.blank_leading = 1;
		pending_reqs.push_back(r);
		r = random_request(REQ_HEX); r.value = 16'h0FFF; r.blank_leading = 1;
		pending_reqs.push_back(r);
		r = random_request(REQ_HEX); r.value = 16'hFFFF; r.blank_leading = 0;
		pending_reqs.push_back(r);
		r = random_request(REQ_DEC_LAST); r.value = 1234; r.shown_digits = 0;
		pending_reqs.push_back(r);
		r = random_request(REQ_DEC_LAST); r.value = 1234; r.shown_digits = 4;
		pending_reqs.push_back(r);
		r = random_request(REQ_DEC_LAST); r.value = 5678; r.shown_digits = 7;
		pending_reqs.push_back(r);
		r = random_request(REQ_DEC_POINT); r.point_position = 1; pending_reqs.push_back(r);
		r = random_request(REQ_DEC_POINT); r.point_position = 4; pending_reqs.push_back(r);
		r = random_request(REQ_DEC_POINT); r.point_position = 0; pending_reqs.push_back(r);
		r = random_request(REQ_DEC_POINT); r.point_position = 7; pending_reqs.push_back(r);
		r = random_request(REQ_TIME); r.minutes = 9; r.seconds = 59; r.tenths = 9;
		r.minute_point = 1; r.blink_position = 4; pending_reqs.push_back(r);
		r = random_request(REQ_TIME); r.minutes = 15; r.seconds = 63; r.tenths = 0;
		r.minute_point = 0; r.blink_position = 2; pending_reqs.push_back(r);
		r = random_request(REQ_TIME); r.minutes = 0; r.seconds = 0; r.tenths = 15;
		r.minute_point = 1; r.blink_position = 7; pending_reqs.push_back(r);
		r = random_request(REQ_CLEAR); pending_reqs.push_back(r);
		r = random_request(REQ_POINT); r.point_position = 1; r.point_on = 1;
		pending_reqs.push_back(r);
		r = random_request(REQ_POINT); r.point_position = 4; r.point_on = 0;
		pending_reqs.push_back(r);
		r = random_request(REQ_POINT); r.point_position = 0; pending_reqs.push_back(r);
		r = random_request(REQ_UNUSED); pending_reqs.push_back(r);
		// Random: every mode, an unused code now and then
		for (int i = 0; i < RandomReqs; i++) begin
			if ($urandom_range(0, 31) == 0)
				r = random_request(REQ_UNUSED);
			else
				r = random_request(3'($urandom_range(0, 6)));
			pending_reqs.push_back(r);
		end
		total_reqs = pending_reqs.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// drain: all requests taken, all writes seen, then a short quiet tail
		do @(negedge clk); while (pending_reqs.size() != 0 || push);
		do @(negedge clk); while (expected_writes.size() != 0);
		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
